[sv/llss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Least-load server selector package
// Shared widths, the entry word layout and the controller state type.
// ----------------------------------------------------------------------------
package llss_pkg;

    localparam int LLSS_TABLE_DEPTH = 64;

    localparam int LOAD_W  = 16;
    localparam int BLOCK_W = 16;
    localparam int TIME_W  = 32;
    localparam int TMO_W   = 16;
    localparam int DROP_W  = 7;

    localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd30;
    localparam logic [DROP_W-1:0] DROP_MAX      = '1;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_SELECT = 1'b1;

    // server_id, old_load, new_load, heartbeat_time, current_time
    localparam int S_TDATA_W  = BLOCK_W + 2 * LOAD_W + 2 * TIME_W;
    // status, found, chosen_block, dropped_count
    localparam int M_FIELDS_W = 2 + BLOCK_W + DROP_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic               valid;
        logic [LOAD_W-1:0]  load;
        logic [BLOCK_W-1:0] block;
        logic [TIME_W-1:0]  hb;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_INS,
        ST_SEL1,
        ST_SEL2,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[sv/least_load_server_selector_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Least-load server selector
// Load-ranked table of server blocks with heartbeat ageing and selection.
// ----------------------------------------------------------------------------
// The table lives in one entry memory (valid, load, block id, heartbeat) that
// is swept one entry per cycle. An update makes one read-modify-write pass
// that removes the old entry, refreshes the block's heartbeat and finds the
// free slot, then inserts the new entry and loads the result. A select makes
// two passes: one finds the least live entry, a second drops the stale
// entries ranked ahead of it. An update with equal loads skips the pass and
// goes straight to loading the result. One item is worked on at a time; its
// result waits in the output register while the next item is taken, and a
// result still waiting there holds the next one back until it is taken.
// After reset a clearing pass zeroes every entry before the first item is
// accepted.
// ----------------------------------------------------------------------------
module least_load_server_selector_top #(
    parameter int TABLE_DEPTH = llss_pkg::LLSS_TABLE_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [llss_pkg::TMO_W-1:0]     cfg_wr_data,   // heartbeat_timeout
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // server_id[15:0], old_load[31:16], new_load[47:32],
    // heartbeat_time[79:48], current_time[111:80]
    input  wire logic [llss_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,       // mode
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status[0], found[1], chosen_block[17:2], dropped_count[24:18], zero pad
    output logic      [llss_pkg::M_TDATA_W-1:0] m_tdata
);
    import llss_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    state_t state_reg, state_next;

    logic [IW-1:0]      rd_idx_reg, rd_idx_next;
    logic               rd_busy_reg, rd_busy_next;
    logic               pipe_vld_reg, pipe_vld_next;
    logic [IW-1:0]      pipe_idx_reg, pipe_idx_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TMO_W-1:0]   timeout_reg, timeout_next;

    logic [BLOCK_W-1:0] id_reg, id_next;
    logic [LOAD_W-1:0]  oldl_reg, oldl_next;
    logic [LOAD_W-1:0]  newl_reg, newl_next;
    logic [TIME_W-1:0]  hb_reg, hb_next;
    logic [TIME_W-1:0]  now_reg, now_next;

    logic               match_done_reg, match_done_next;
    logic               slot_found_reg, slot_found_next;
    logic [IW-1:0]      slot_idx_reg, slot_idx_next;

    logic               best_found_reg, best_found_next;
    logic [LOAD_W-1:0]  best_load_reg, best_load_next;
    logic [BLOCK_W-1:0] best_block_reg, best_block_next;
    logic [IW-1:0]      best_idx_reg, best_idx_next;
    logic [DROP_W-1:0]  drop_cnt_reg, drop_cnt_next;

    logic               res_status_reg, res_status_next;
    logic               res_found_reg, res_found_next;
    logic [BLOCK_W-1:0] res_chosen_reg, res_chosen_next;
    logic [DROP_W-1:0]  res_drop_reg, res_drop_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               ram_we;
    logic [IW-1:0]      ram_wr_addr;
    entry_t             ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_data;
    entry_t             ent;

    logic               last_entry;
    logic               is_match;
    logic               is_stale;
    logic               out_free;

    llss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_data)
    );

    assign ent        = entry_t'(ram_rd_data);
    assign last_entry = pipe_vld_reg && (pipe_idx_reg == LAST_IDX);
    assign is_match   = ent.valid && (ent.load == oldl_reg) && (ent.block == id_reg)
                        && !match_done_reg;
    // offline when now - hb > timeout, taken as signed: compare in 33 bits
    assign is_stale   = {1'b0, now_reg} > ({1'b0, ent.hb} + (TIME_W + 1)'(timeout_reg));
    assign out_free   = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        rd_busy_next    = rd_busy_reg;
        pipe_vld_next   = 1'b0;
        pipe_idx_next   = rd_idx_reg;
        m_tvalid_next   = m_tvalid_reg;
        timeout_next    = cfg_wr_en ? cfg_wr_data : timeout_reg;
        id_next         = id_reg;
        oldl_next       = oldl_reg;
        newl_next       = newl_reg;
        hb_next         = hb_reg;
        now_next        = now_reg;
        match_done_next = match_done_reg;
        slot_found_next = slot_found_reg;
        slot_idx_next   = slot_idx_reg;
        best_found_next = best_found_reg;
        best_load_next  = best_load_reg;
        best_block_next = best_block_reg;
        best_idx_next   = best_idx_reg;
        drop_cnt_next   = drop_cnt_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_chosen_next = res_chosen_reg;
        res_drop_next   = res_drop_reg;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_wr_addr     = pipe_idx_reg;
        ram_wr_data     = ent;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // issue one read per cycle during a pass
        if (rd_busy_reg) begin
            pipe_vld_next = 1'b1;
            if (rd_idx_reg == LAST_IDX) begin
                rd_busy_next = 1'b0;
            end else begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we      = 1'b1;
                ram_wr_addr = rd_idx_reg;
                ram_wr_data = '0;
                if (rd_idx_reg == LAST_IDX) begin
                    rd_idx_next = '0;
                    state_next  = ST_IDLE;
                end else begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    id_next         = s_tdata[15:0];
                    oldl_next       = s_tdata[31:16];
                    newl_next       = s_tdata[47:32];
                    hb_next         = s_tdata[79:48];
                    now_next        = s_tdata[111:80];
                    match_done_next = 1'b0;
                    slot_found_next = 1'b0;
                    best_found_next = 1'b0;
                    drop_cnt_next   = '0;
                    res_status_next = 1'b0;
                    res_found_next  = 1'b0;
                    res_chosen_next = '0;
                    res_drop_next   = '0;
                    if (s_tuser == MODE_SELECT) begin
                        rd_idx_next  = '0;
                        rd_busy_next = 1'b1;
                        state_next   = ST_SEL1;
                    end else if (s_tdata[31:16] == s_tdata[47:32]) begin
                        // equal loads: nothing to do
                        state_next = ST_DONE;
                    end else begin
                        rd_idx_next  = '0;
                        rd_busy_next = 1'b1;
                        state_next   = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                if (pipe_vld_reg) begin
                    if (is_match) begin
                        match_done_next   = 1'b1;
                        ram_we            = 1'b1;
                        ram_wr_data.valid = 1'b0;
                    end else if (ent.valid && (ent.block == id_reg)) begin
                        ram_we         = 1'b1;
                        ram_wr_data.hb = hb_reg;
                    end
                    if (!slot_found_reg && (!ent.valid || is_match)) begin
                        slot_found_next = 1'b1;
                        slot_idx_next   = pipe_idx_reg;
                    end
                    if (last_entry) begin
                        state_next = ST_INS;
                    end
                end
            end
            ST_INS: begin
                ram_wr_addr       = slot_idx_reg;
                ram_wr_data.valid = 1'b1;
                ram_wr_data.load  = newl_reg;
                ram_wr_data.block = id_reg;
                ram_wr_data.hb    = hb_reg;
                ram_we            = slot_found_reg;
                res_status_next   = !slot_found_reg;
                state_next        = ST_DONE;
            end
            ST_SEL1: begin
                if (pipe_vld_reg) begin
                    if (ent.valid && !is_stale && (!best_found_reg ||
                        ({ent.load, ent.block} < {best_load_reg, best_block_reg}))) begin
                        best_found_next = 1'b1;
                        best_load_next  = ent.load;
                        best_block_next = ent.block;
                        best_idx_next   = pipe_idx_reg;
                    end
                    if (last_entry) begin
                        rd_idx_next  = '0;
                        rd_busy_next = 1'b1;
                        state_next   = ST_SEL2;
                    end
                end
            end
            ST_SEL2: begin
                if (pipe_vld_reg) begin
                    // drop every entry ranked ahead of the chosen one, or all if none was chosen
                    if (ent.valid && (!best_found_reg ||
                        ({ent.load, ent.block, pipe_idx_reg} <
                         {best_load_reg, best_block_reg, best_idx_reg}))) begin
                        ram_we            = 1'b1;
                        ram_wr_data.valid = 1'b0;
                        if (drop_cnt_reg != DROP_MAX) begin
                            drop_cnt_next = drop_cnt_reg + 1'b1;
                        end
                    end
                    if (last_entry) begin
                        res_found_next  = best_found_reg;
                        res_chosen_next = best_found_reg ? best_block_reg : '0;
                        res_drop_next   = drop_cnt_next;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, res_drop_reg,
                                     res_chosen_reg, res_found_reg, res_status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            rd_idx_reg   <= '0;
            rd_busy_reg  <= 1'b0;
            pipe_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            timeout_reg  <= TIMEOUT_RESET;
        end else begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            rd_busy_reg  <= rd_busy_next;
            pipe_vld_reg <= pipe_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            timeout_reg  <= timeout_next;
        end
    end

    always_ff @(posedge aclk) begin
        pipe_idx_reg   <= pipe_idx_next;
        id_reg         <= id_next;
        oldl_reg       <= oldl_next;
        newl_reg       <= newl_next;
        hb_reg         <= hb_next;
        now_reg        <= now_next;
        match_done_reg <= match_done_next;
        slot_found_reg <= slot_found_next;
        slot_idx_reg   <= slot_idx_next;
        best_found_reg <= best_found_next;
        best_load_reg  <= best_load_next;
        best_block_reg <= best_block_next;
        best_idx_reg   <= best_idx_next;
        drop_cnt_reg   <= drop_cnt_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_chosen_reg <= res_chosen_next;
        res_drop_reg   <= res_drop_next;
        m_tdata_reg    <= m_tdata_next;
    end

`ifndef SYNTH
    // a result never reports both a dropped insert and a found block
    a_status_found_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("status and found both set");

    // no item is taken while the entry memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input ready during clearing pass");

    // a write-back never hits the entry being read in the same cycle
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && rd_busy_reg) |-> (ram_wr_addr != rd_idx_reg))
        else $error("read and write to the same entry");

    // an update pass ends in the insert state, never straight in idle
    a_pass_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_entry && (state_reg == ST_UPD)) |=> (state_reg == ST_INS))
        else $error("update pass did not reach insert");
`endif

endmodule
`default_nettype wire

[sv/llss_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module llss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[verif/least_load_server_selector_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-load server selector testbench
// Drives update and select items through the stream input, predicts every
// result from a table model kept here, and compares each result field by field.
// Phases under different heartbeat timeouts fill the table, age it out and
// wrap the clock. Random idling is applied on both sides of the block, but for the fill phase.
// ----------------------------------------------------------------------------
module least_load_server_selector_top_test;
    import llss_pkg::*;

    localparam int DEPTH       = LLSS_TABLE_DEPTH;
    localparam int ID_POOL     = 40;
    localparam int IDLE_PCT    = 26;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct {
        logic               mode;
        logic [BLOCK_W-1:0] server_id;
        logic [LOAD_W-1:0]  old_load;
        logic [LOAD_W-1:0]  new_load;
        logic [TIME_W-1:0]  hb_time;
        logic [TIME_W-1:0]  now_time;
    } lb_item_t;

    typedef struct {
        logic               status;
        logic               found;
        logic [BLOCK_W-1:0] chosen;
        logic [DROP_W-1:0]  dropped;
    } lb_pick_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [TMO_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    wire                  s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    wire                  m_tvalid;
    logic                 m_tready    = 1'b0;
    wire  [M_TDATA_W-1:0] m_tdata;

    // table model
    logic               tbl_valid [DEPTH];
    logic [LOAD_W-1:0]  tbl_load  [DEPTH];
    logic [BLOCK_W-1:0] tbl_block [DEPTH];
    logic [TIME_W-1:0]  tbl_hb    [DEPTH];
    logic [TMO_W-1:0]   model_timeout = TIMEOUT_RESET;

    lb_item_t    pending_items[$];
    lb_pick_t    expected_picks[$];
    lb_item_t    drv_item;
    int          mismatch_count = 0;
    int          result_count   = 0;
    int unsigned cycle_count    = 0;
    bit          steady_run     = 1'b0;

    // stimulus shaping: a pool of block ids and the load each was last moved to
    logic [BLOCK_W-1:0] pool_ids   [ID_POOL];
    logic [LOAD_W-1:0]  pool_load  [ID_POOL];
    bit                 pool_known [ID_POOL];
    logic [TIME_W-1:0]  gen_now;

    least_load_server_selector_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic lb_pick_t predict_schedule(lb_item_t it);
        lb_pick_t   r;
        int         slot;
        int         best;
        bit         removed;
        bit         done;
        longint     age;
        r = '{status: 1'b0, found: 1'b0, chosen: '0, dropped: '0};
        if (it.mode == MODE_UPDATE) begin
            if (it.old_load != it.new_load) begin
                // remove one entry with the exact old key, then take the lowest free slot
                removed = 1'b0;
                for (int i = 0; i < DEPTH; i++) begin
                    if (!removed && tbl_valid[i] && tbl_load[i] == it.old_load &&
                        tbl_block[i] == it.server_id) begin
                        tbl_valid[i] = 1'b0;
                        removed      = 1'b1;
                    end
                end
                slot = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (slot < 0 && !tbl_valid[i]) slot = i;
                if (slot >= 0) begin
                    tbl_valid[slot] = 1'b1;
                    tbl_load[slot]  = it.new_load;
                    tbl_block[slot] = it.server_id;
                end else begin
                    r.status = 1'b1;
                end
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_valid[i] && tbl_block[i] == it.server_id) tbl_hb[i] = it.hb_time;
            end
        end else begin
            done = 1'b0;
            while (!done) begin
                best = -1;
                for (int i = 0; i < DEPTH; i++) begin
                    if (tbl_valid[i] && (best < 0 || tbl_load[i] < tbl_load[best] ||
                        (tbl_load[i] == tbl_load[best] && tbl_block[i] < tbl_block[best])))
                        best = i;
                end
                if (best < 0) begin
                    done = 1'b1;
                end else begin
                    // signed age: a heartbeat in the future counts as live
                    age = longint'({32'd0, it.now_time}) - longint'({32'd0, tbl_hb[best]});
                    if (age > longint'({48'd0, model_timeout})) begin
                        tbl_valid[best] = 1'b0;
                        if (r.dropped != DROP_MAX) r.dropped++;
                    end else begin
                        r.found  = 1'b1;
                        r.chosen = tbl_block[best];
                        done     = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("result %0d: %s", result_count, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // sender: present the next pending item once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_picks.push_back(predict_schedule(drv_item));
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 &&
                    (steady_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    drv_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {drv_item.now_time, drv_item.hb_time, drv_item.new_load,
                                 drv_item.old_load, drv_item.server_id};
                    s_tuser  <= drv_item.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall at random, check every accepted result
    always @(posedge aclk) begin : result_monitor
        lb_pick_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_picks.size() == 0) begin
                    report_mismatch($sformatf("unexpected result 0x%0h", m_tdata));
                end else begin
                    want = expected_picks.pop_front();
                    compare_field("status", 32'(m_tdata[0]), 32'(want.status));
                    compare_field("found", 32'(m_tdata[1]), 32'(want.found));
                    compare_field("chosen_block", 32'(m_tdata[17:2]), 32'(want.chosen));
                    compare_field("dropped_count", 32'(m_tdata[24:18]), 32'(want.dropped));
                end
                result_count++;
            end
            m_tready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_update(input logic [15:0] id, input logic [15:0] from_load,
                                input logic [15:0] to_load, input logic [31:0] hb);
        pending_items.push_back('{MODE_UPDATE, id, from_load, to_load, hb, 32'd0});
    endtask

    task automatic queue_select(input logic [31:0] now);
        pending_items.push_back('{MODE_SELECT, 16'd0, 16'd0, 16'd0, 32'd0, now});
    endtask

    task automatic drain_results();
        while (pending_items.size() != 0 || s_tvalid || expected_picks.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [TMO_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_timeout = value;
    endtask

    // mostly well-formed moves of pooled blocks, selects that advance time, some noise
    task automatic plan_phase(input int count, input int select_pct, input int match_pct,
                              input int step_max);
        lb_item_t it;
        int       p;
        int       roll;
        for (int k = 0; k < count; k++) begin
            it.mode      = MODE_UPDATE;
            it.server_id = BLOCK_W'($urandom());
            it.old_load  = LOAD_W'($urandom());
            it.new_load  = LOAD_W'($urandom());
            it.hb_time   = $urandom();
            it.now_time  = $urandom();
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                it.mode = 1'($urandom_range(0, 1));
            end else if (roll < 4 + select_pct) begin
                gen_now += $urandom_range(0, step_max);
                it.mode     = MODE_SELECT;
                it.now_time = gen_now;
            end else begin
                p = $urandom_range(0, ID_POOL - 1);
                it.server_id = pool_ids[p];
                if (pool_known[p] && $urandom_range(0, 99) < match_pct)
                    it.old_load = pool_load[p];
                else
                    it.old_load = LOAD_W'($urandom_range(0, 63));
                if ($urandom_range(0, 99) < 3)
                    it.new_load = it.old_load;
                else if ($urandom_range(0, 99) < 80)
                    it.new_load = LOAD_W'($urandom_range(0, 63));
                if ($urandom_range(0, 99) < 8)
                    it.hb_time = gen_now + $urandom_range(1, 4 * step_max + 1);
                else
                    it.hb_time = gen_now - $urandom_range(0, 2 * step_max);
                pool_load[p]  = it.new_load;
                pool_known[p] = 1'b1;
            end
            pending_items.push_back(it);
        end
    endtask

    initial begin
        logic [TMO_W-1:0] tmo;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        foreach (pool_ids[i]) begin
            pool_ids[i]   = BLOCK_W'($urandom());
            pool_known[i] = 1'b0;
        end
        pool_ids[0] = 16'h0000;
        pool_ids[1] = 16'hFFFF;
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, under the reset timeout
        queue_select(32'd0);                                  // empty table
        queue_update(16'd5, 16'd10, 16'd10, 32'd77);          // equal loads: no change
        queue_update(16'h0000, 16'h0000, 16'hFFFF, 32'd100);
        queue_update(16'hFFFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF); // no match, still inserted
        queue_update(16'd7, 16'd1, 16'd2, 32'd90);
        queue_update(16'd7, 16'd1, 16'd2, 32'd95);            // duplicate key
        queue_update(16'd7, 16'd2, 16'd3, 32'd96);            // removes one duplicate only
        queue_update(16'd8, 16'd0, 16'd2, 32'd10);
        queue_update(16'd9, 16'd0, 16'd1, 32'd20);
        queue_select(32'd130);                                // future heartbeat is live
        queue_update(16'hFFFF, 16'h0000, 16'd60000, 32'd50);
        queue_select(32'd130);                                // drops ahead, age equal to timeout
        queue_select(32'd131);                                // drops the last one
        queue_select(32'hFFFF_FFFF);
        queue_update(16'hA5A5, 16'h8000, 16'h0000, 32'd0);
        queue_update(16'd3, 16'd9, 16'd4, 32'hFFFF_FFF0);
        queue_select(32'hFFFF_FFFF);
        queue_select(32'd0);
        drain_results();

        gen_now = 32'd200;
        // fill the table until inserts are refused; no idling here
        steady_run = 1'b1;
        write_timeout(16'hFFFF);
        plan_phase(200, 5, 30, 20);
        drain_results();
        steady_run = 1'b0;

        write_timeout(16'd1);
        plan_phase(150, 40, 80, 3);
        drain_results();

        write_timeout(16'd0);
        plan_phase(150, 35, 80, 2);
        drain_results();

        write_timeout(TIMEOUT_RESET);
        plan_phase(250, 30, 85, 15);
        drain_results();

        tmo = TMO_W'($urandom_range(2, 65534));
        write_timeout(tmo);
        plan_phase(200, 30, 80, int'(tmo) / 4 + 1);
        drain_results();

        // let the clock wrap
        gen_now = 32'hFFFF_FF00;
        write_timeout(16'd1000);
        plan_phase(200, 25, 75, 50);
        drain_results();

        repeat (2 * DEPTH + 20) @(posedge aclk);
        if (expected_picks.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_picks.size()));
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
sv/llss_pkg.sv
sv/llss_ram.sv
sv/least_load_server_selector_top.sv
verif/least_load_server_selector_top_test.sv
